@@ rtl/near_best_score_filter_macros.svh @@
`ifndef NEAR_BEST_SCORE_FILTER_MACROS_SVH
`define NEAR_BEST_SCORE_FILTER_MACROS_SVH

// same-cycle implication
`define NBSF_ASSERT_NOW(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// next-cycle implication
`define NBSF_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

@@ rtl/nbsf_pkg.sv @@
`timescale 1ns / 1ps

package nbsf_pkg;

    localparam int SCORE_W = 27;
    localparam int IDX_W   = 6;
    localparam int FRAC_W  = 17;
    localparam int IN_W    = 160;
    localparam int OUT_W   = 40;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    typedef logic signed [SCORE_W-1:0] score_t;

    typedef struct packed {
        logic   last;
        score_t score;
    } rec_t;

    typedef struct packed {
        logic busy;
        logic full;
    } stat_t;

endpackage

@@ rtl/nbsf_score.sv @@
`timescale 1ns / 1ps

module nbsf_score (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [nbsf_pkg::IN_W-1:0] in_data,
    input  logic                      in_last,
    output logic                      out_valid,
    input  logic                      out_ready,
    output nbsf_pkg::rec_t            out_rec
);
    import nbsf_pkg::*;

    logic        v1_reg;
    logic        last1_reg;
    logic [24:0] sum_mr_reg;
    logic [23:0] mis_reg;
    logic [20:0] gapc_reg;
    logic [24:0] gapb_reg;
    logic        v2_reg;
    rec_t        rec_reg;
    logic        adv;
    score_t      score_next;

    assign adv      = !v2_reg || out_ready;
    assign in_ready = adv;

    // matches + repeats - mismatches - 2*gap count - gap bases/2
    assign score_next = SCORE_W'(sum_mr_reg) - SCORE_W'(mis_reg)
                      - {5'b0, gapc_reg, 1'b0} - SCORE_W'(gapb_reg[24:1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_mr_reg <= 25'(in_data[23:0]) + 25'(in_data[47:24]);
            mis_reg    <= in_data[71:48];
            gapc_reg   <= 21'(in_data[91:72]) + 21'(in_data[111:92]);
            gapb_reg   <= 25'(in_data[135:112]) + 25'(in_data[159:136]);
            last1_reg  <= in_last;
            rec_reg    <= '{last: last1_reg, score: score_next};
        end
    end

    assign out_valid = v2_reg;
    assign out_rec   = rec_reg;

endmodule

@@ rtl/nbsf_queue.sv @@
`timescale 1ns / 1ps

module nbsf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  nbsf_pkg::rec_t in_rec,
    output logic           out_valid,
    input  logic           out_ready,
    output nbsf_pkg::rec_t out_rec
);
    import nbsf_pkg::*;

    rec_t            entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   count_reg;
    logic [Q_AW:0]   count_next;
    logic            push;
    logic            pop;

    assign in_ready  = count_reg != (Q_AW+1)'(Q_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_rec   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (Q_AW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (Q_AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_rec;
    end

endmodule

@@ rtl/nbsf_group.sv @@
`timescale 1ns / 1ps

module nbsf_group #(
    parameter int GROUP_DEPTH = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [nbsf_pkg::FRAC_W-1:0] frac,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  nbsf_pkg::rec_t              in_rec,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [nbsf_pkg::IDX_W-1:0]  out_index,
    output nbsf_pkg::score_t            out_score,
    output logic                        out_keep,
    output logic                        out_last,
    output logic                        out_ovf,
    output nbsf_pkg::stat_t             stat
);
    import nbsf_pkg::*;

    localparam int AW = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
    localparam int CW = $clog2(GROUP_DEPTH + 1);

    localparam logic [1:0] ST_COLLECT = 2'd0;
    localparam logic [1:0] ST_MUL     = 2'd1;
    localparam logic [1:0] ST_EMIT    = 2'd2;

    score_t                  mem [GROUP_DEPTH];
    score_t                  rd_data_reg;
    logic [1:0]              state_reg;
    logic [CW-1:0]           count_reg;
    score_t                  best_reg;
    logic                    ovf_reg;
    logic [AW-1:0]           idx_reg;
    logic signed [44:0]      rhs_reg;
    logic                    out_valid_reg;
    logic [IDX_W-1:0]        out_index_reg;
    score_t                  out_score_reg;
    logic                    out_keep_reg;
    logic                    out_last_reg;
    logic                    out_ovf_reg;

    logic                    pop;
    logic                    has_room;
    logic                    wr_en;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic                    out_free;
    logic                    is_last;
    logic                    keep_next;
    logic [FRAC_W-1:0]       frac_sat;
    logic [FRAC_W-1:0]       diff;
    logic signed [44:0]      rhs_next;

    assign in_ready = state_reg == ST_COLLECT;
    assign pop      = in_valid && in_ready;
    assign has_room = count_reg < CW'(GROUP_DEPTH);
    assign wr_en    = pop && has_room;
    assign out_free = !out_valid_reg || out_ready;
    assign is_last  = (CW'(idx_reg) + CW'(1)) == count_reg;
    assign rd_en    = (state_reg == ST_MUL)
                   || (state_reg == ST_EMIT && out_free && !is_last);
    assign rd_addr  = (state_reg == ST_EMIT) ? idx_reg + AW'(1) : idx_reg;

    // fractions above one clamp to one
    assign frac_sat = (frac > FRAC_ONE) ? FRAC_ONE : frac;
    assign diff     = FRAC_ONE - frac_sat;
    assign rhs_next = best_reg * $signed({1'b0, diff});
    assign keep_next = $signed({{2{rd_data_reg[SCORE_W-1]}}, rd_data_reg, 16'h0000})
                       >= rhs_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[AW-1:0]] <= in_rec.score;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
            rhs_reg <= rhs_next;
        if (state_reg == ST_EMIT && out_free)
        begin
            out_index_reg <= IDX_W'(idx_reg);
            out_score_reg <= rd_data_reg;
            out_keep_reg  <= keep_next;
            out_last_reg  <= is_last;
            out_ovf_reg   <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            count_reg     <= '0;
            best_reg      <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_COLLECT:
                begin
                    if (pop)
                    begin
                        if (in_rec.score > best_reg)
                            best_reg <= in_rec.score;
                        if (has_room)
                            count_reg <= count_reg + CW'(1);
                        else
                            ovf_reg <= 1'b1;
                        if (in_rec.last)
                            state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (is_last)
                        begin
                            state_reg <= ST_COLLECT;
                            count_reg <= '0;
                            best_reg  <= '0;
                            ovf_reg   <= 1'b0;
                            idx_reg   <= '0;
                        end
                        else
                            idx_reg <= idx_reg + AW'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_COLLECT;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_score = out_score_reg;
    assign out_keep  = out_keep_reg;
    assign out_last  = out_last_reg;
    assign out_ovf   = out_ovf_reg;
    assign stat      = '{busy: state_reg != ST_COLLECT, full: !has_room};

endmodule

@@ rtl/near_best_score_filter.sv @@
`timescale 1ns / 1ps
// channel     dir  handshake                      payload
// s_axis      in   s_axis_tvalid / s_axis_tready  tdata: alignment counts, tlast: group end
// m_axis      out  m_axis_tvalid / m_axis_tready  tdata: index, score; tlast; tuser: keep, ovf
// cfg         in   cfg_we                         cfg_wdata: near-best fraction, Q1.16
//
// Front scores one record a cycle while the queue accepts, through the sum registers
// and then the score register, into a 4-item queue. Back takes one record a cycle
// while collecting; at group end ST_MUL does the threshold multiply, then one result a
// cycle leaves the score memory while m_axis is not stalled. The queue stalls only
// while the back drains. rst_n is asynchronous; the score memory is not cleared.
module near_best_score_filter #(
    parameter int GROUP_DEPTH = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [nbsf_pkg::FRAC_W-1:0] cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // match, repeat match, mismatch, query gap count, target gap count,
    // query gap bases, target gap bases
    input  logic [nbsf_pkg::IN_W-1:0]   s_axis_tdata,
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // record_index, record_score, zero fill
    output logic [nbsf_pkg::OUT_W-1:0]  m_axis_tdata,
    output logic                        m_axis_tlast,
    // keep, overflow
    output logic [1:0]                  m_axis_tuser
);
    import nbsf_pkg::*;

`include "near_best_score_filter_macros.svh"

    logic [FRAC_W-1:0] frac_reg;
    logic              f_valid;
    logic              f_ready;
    rec_t              f_rec;
    logic              q_valid;
    logic              q_ready;
    rec_t              q_rec;
    logic [IDX_W-1:0]  out_index;
    score_t            out_score;
    logic              out_keep;
    logic              out_ovf;
    stat_t             stat;
    logic              q_pop;
    logic              m_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frac_reg <= FRAC_W'(66);
        else if (cfg_we)
            frac_reg <= cfg_wdata;
    end

    nbsf_score u_score (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_rec   (f_rec)
    );

    nbsf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_rec    (f_rec),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_rec   (q_rec)
    );

    nbsf_group #(
        .GROUP_DEPTH (GROUP_DEPTH)
    ) u_group (
        .clk       (clk),
        .rst_n     (rst_n),
        .frac      (frac_reg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_rec    (q_rec),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_index (out_index),
        .out_score (out_score),
        .out_keep  (out_keep),
        .out_last  (m_axis_tlast),
        .out_ovf   (out_ovf),
        .stat      (stat)
    );

    assign m_axis_tdata = {(OUT_W-IDX_W-SCORE_W)'(0), out_score, out_index};
    assign m_axis_tuser = {out_ovf, out_keep};

    assign q_pop   = q_valid && q_ready;
    assign m_stall = m_axis_tvalid && !m_axis_tready;

    `NBSF_ASSERT_NOW(a_no_pop_busy, clk, rst_n, stat.busy, !q_pop, "pop during drain")
    `NBSF_ASSERT_NEXT(a_end_drains, clk, rst_n, q_pop && q_rec.last, stat.busy, "no drain")
    `NBSF_ASSERT_NEXT(a_out_held, clk, rst_n, m_stall, m_axis_tvalid, "result withdrawn")
    `NBSF_ASSERT_NEXT(a_full, clk, rst_n, stat.full && q_ready, stat.full || stat.busy, "full")

endmodule
